### rtl/shs_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
// Depends on nothing; used by shs_core and sha256_stream_hasher.

package shs_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumHash = 8;
  localparam int unsigned BlkW    = 16;
  localparam int unsigned NumRnd  = 64;
  localparam int unsigned LenW    = 64;

  localparam logic [WordW-1:0] PadMark = 32'h8000_0000;
  localparam logic [3:0]       LenSlot = 4'd14;

  // One input item and one result item.
  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef logic [NumHash-1:0][WordW-1:0] chain_t;

  // Control from the padding sequencer to the round engine.
  typedef struct packed {
    logic             push;
    logic [WordW-1:0] word;
    logic             restart;
  } core_ctrl_t;

  // Status from the round engine.
  typedef struct packed {
    logic       ready;
    logic [3:0] fill;
  } core_stat_t;

  typedef enum logic [1:0] {
    CORE_LOAD,
    CORE_ROUND,
    CORE_FINAL
  } core_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LENLO,
    ST_WAIT,
    ST_OUT
  } seq_state_e;

  // Initial chaining words.
  localparam chain_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [WordW-1:0] ror32(input logic [WordW-1:0] v, input int amt);
    logic [2*WordW-1:0] tmp;
    tmp = {v, v} >> amt;
    return tmp[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] v);
    return ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] v);
    return ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sig0(input logic [WordW-1:0] v);
    return ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sig1(input logic [WordW-1:0] v);
    return ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
  endfunction

  function automatic logic [WordW-1:0] choose(input logic [WordW-1:0] e,
                                               input logic [WordW-1:0] f,
                                               input logic [WordW-1:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [WordW-1:0] majority(input logic [WordW-1:0] a,
                                                 input logic [WordW-1:0] b,
                                                 input logic [WordW-1:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  // Round constants.
  function automatic logic [WordW-1:0] round_k(input logic [5:0] t);
    logic [WordW-1:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### rtl/shs_core.sv
// Round engine: gathers 16-word blocks, expands the schedule in a sliding
// window and runs one compression round per cycle. Depends on shs_pkg.

module shs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  shs_pkg::core_ctrl_t ctrl_i,
  output shs_pkg::core_stat_t stat_o,
  output shs_pkg::chain_t     chain_o
);

  shs_pkg::core_state_e state_q, state_d;
  logic [3:0]           fill_q;
  logic [5:0]           round_q;
  logic [shs_pkg::BlkW-1:0][shs_pkg::WordW-1:0] win_q, win_d;
  shs_pkg::chain_t      work_q, work_d;
  shs_pkg::chain_t      chain_q;
  logic                 ready;
  logic                 block_full;
  logic [shs_pkg::WordW-1:0] sched_new, t1, t2;

  assign ready      = (state_q == shs_pkg::CORE_LOAD);
  assign block_full = ctrl_i.push && (fill_q == 4'd15);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      shs_pkg::CORE_LOAD: begin
        if (block_full) state_d = shs_pkg::CORE_ROUND;
      end
      shs_pkg::CORE_ROUND: begin
        if (round_q == 6'(shs_pkg::NumRnd - 1)) state_d = shs_pkg::CORE_FINAL;
      end
      shs_pkg::CORE_FINAL: state_d = shs_pkg::CORE_LOAD;
      default: state_d = shs_pkg::CORE_LOAD;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    stat_o.ready = ready;
    stat_o.fill  = fill_q;
    chain_o      = chain_q;
  end

  // Schedule word and the two round sums.
  always_comb begin
    sched_new = shs_pkg::small_sig1(win_q[14]) + win_q[9]
              + shs_pkg::small_sig0(win_q[1]) + win_q[0];
    t1 = work_q[7] + shs_pkg::big_sig1(work_q[4])
       + shs_pkg::choose(work_q[4], work_q[5], work_q[6])
       + shs_pkg::round_k(round_q) + win_q[0];
    t2 = shs_pkg::big_sig0(work_q[0]) + shs_pkg::majority(work_q[0], work_q[1], work_q[2]);
  end

  // The window shifts toward entry 0 on each pushed word and each round.
  always_comb begin
    win_d = win_q;
    if (ctrl_i.push || state_q == shs_pkg::CORE_ROUND) begin
      for (int i = 0; i < shs_pkg::BlkW - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[shs_pkg::BlkW-1] = ctrl_i.push ? ctrl_i.word : sched_new;
    end
  end

  // Working words: loaded from the chain when a block fills, then one round a cycle.
  always_comb begin
    work_d = work_q;
    if (block_full) begin
      work_d = chain_q;
    end else if (state_q == shs_pkg::CORE_ROUND) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    work_q <= work_d;
  end

  // Control state and chaining words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shs_pkg::CORE_LOAD;
      fill_q  <= '0;
      round_q <= '0;
      chain_q <= shs_pkg::InitHash;
    end else begin
      state_q <= state_d;
      if (ctrl_i.push) fill_q <= fill_q + 4'd1;
      if (state_q == shs_pkg::CORE_ROUND) round_q <= round_q + 6'd1;
      if (ctrl_i.restart) begin
        chain_q <= shs_pkg::InitHash;
      end else if (state_q == shs_pkg::CORE_FINAL) begin
        for (int i = 0; i < shs_pkg::NumHash; i++) begin
          chain_q[i] <= chain_q[i] + work_q[i];
        end
      end
    end
  end

  // Words are pushed and the chain restarted only between compressions.
  a_push_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> ready) else $error("word pushed during compression");

  a_restart_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.restart |-> ready) else $error("chain restarted during compression");

  // A full block starts the rounds at round zero.
  a_block_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_full |=> (state_q == shs_pkg::CORE_ROUND && round_q == 6'd0 && fill_q == 4'd0))
    else $error("full block did not start compression");

  // The round counter rests at zero outside the rounds.
  a_round_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != shs_pkg::CORE_ROUND) |-> (round_q == 6'd0))
    else $error("round counter not at rest");

endmodule

### rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: input handshake, message padding,
// length counting and digest output. Depends on shs_pkg and shs_core.

// Each message word is one input item; after an item marked last the block
// delivers the eight digest words as eight result items, word 0 first.
// Words enter at one per cycle until a 16-word block is full; the block then
// runs its single round unit through the 64 rounds and then adds the working
// words into the chaining words. After the last word, padding words enter at
// one per cycle while the round unit is loading (up to 15 more, or a second
// block when fewer than two word slots remain after the end mark), each full
// block again passes through the round unit, and the eight digest items then
// leave through an output register at up to one per cycle. The next
// message's first word may be accepted while the final digest item still
// waits to be taken.

module sha256_stream_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  shs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output shs_pkg::out_item_t out_item_o
);

  shs_pkg::seq_state_e state_q, state_d;
  shs_pkg::core_ctrl_t ctrl;
  shs_pkg::core_stat_t stat;
  shs_pkg::chain_t     chain;

  logic [shs_pkg::LenW-1:0] len_q;
  logic [2:0]               idx_q;
  logic                     out_valid_q;
  shs_pkg::out_item_t       out_item_q;

  logic                     accept;
  logic                     load_out;
  logic [2:0]               nbytes;
  logic [4:0]               shamt;
  logic [31:0]              padded;

  shs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .chain_o (chain)
  );

  // Byte count of the last word, saturated at four, and its padded form.
  always_comb begin
    nbytes = (in_item_i.valid_bytes > 3'd4) ? 3'd4 : in_item_i.valid_bytes;
    shamt  = {nbytes[1:0], 3'b000};
    padded = (in_item_i.message_word & ~(32'hFFFF_FFFF >> shamt))
           | (shs_pkg::PadMark >> shamt);
  end

  assign accept   = in_valid_i && in_ready_o;
  assign load_out = (state_q == shs_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  // Next state of the padding sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      shs_pkg::ST_IDLE: begin
        if (accept && in_item_i.last) begin
          state_d = nbytes[2] ? shs_pkg::ST_MARK : shs_pkg::ST_ZERO;
        end
      end
      shs_pkg::ST_MARK: begin
        if (stat.ready) state_d = shs_pkg::ST_ZERO;
      end
      shs_pkg::ST_ZERO: begin
        if (stat.ready && stat.fill == shs_pkg::LenSlot) state_d = shs_pkg::ST_LENLO;
      end
      shs_pkg::ST_LENLO: begin
        if (stat.ready) state_d = shs_pkg::ST_WAIT;
      end
      shs_pkg::ST_WAIT: begin
        if (stat.ready) state_d = shs_pkg::ST_OUT;
      end
      shs_pkg::ST_OUT: begin
        if (load_out && idx_q == 3'd7) state_d = shs_pkg::ST_IDLE;
      end
      default: state_d = shs_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the padding sequencer: input ready, the word pushed into the round engine and the chain restart.
  always_comb begin
    in_ready_o   = 1'b0;
    ctrl.push    = 1'b0;
    ctrl.word    = '0;
    ctrl.restart = 1'b0;
    case (state_q)
      shs_pkg::ST_IDLE: begin
        in_ready_o = stat.ready;
        ctrl.push  = accept;
        ctrl.word  = (in_item_i.last && !nbytes[2]) ? padded : in_item_i.message_word;
      end
      shs_pkg::ST_MARK: begin
        ctrl.push = stat.ready;
        ctrl.word = shs_pkg::PadMark;
      end
      shs_pkg::ST_ZERO: begin
        ctrl.push = stat.ready;
        ctrl.word = (stat.fill == shs_pkg::LenSlot) ? len_q[63:32] : '0;
      end
      shs_pkg::ST_LENLO: begin
        ctrl.push = stat.ready;
        ctrl.word = len_q[31:0];
      end
      shs_pkg::ST_OUT: begin
        ctrl.restart = load_out && (idx_q == 3'd7);
      end
      default: begin
        ctrl.push = 1'b0;
      end
    endcase
  end

  // Sequencer state, message length in bits and the digest output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shs_pkg::ST_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.restart) begin
        len_q <= '0;
      end else if (accept) begin
        len_q <= len_q + (in_item_i.last ? {58'd0, nbytes, 3'b000} : 64'd32);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_item_q.digest_word <= chain[idx_q];
      out_item_q.word_index  <= idx_q;
      out_item_q.last_word   <= (idx_q == 3'd7);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
